### src/apr_pkg.sv
// ----------------------------------------------------------------------------
// apr_pkg
// Shared types and constants for the aging page replacement block.
// ----------------------------------------------------------------------------
package apr_pkg;

   localparam int FRAMES_DEF    = 64;
   localparam int PAGE_BITS_DEF = 20;

   localparam int AGE_W        = 8;
   localparam logic [AGE_W-1:0] AGE_TOP = 8'h80;

   localparam int PAGE_FIELD_W = 20;
   localparam int IDX_FIELD_W  = 6;
   localparam int TOTAL_W      = 32;

   localparam int REQ_TDATA_W  = 24;
   localparam int RSP_TDATA_W  = 72;

   // write strobes from the sequencer to the frame store
   typedef struct packed {
      logic age_we;
      logic tag_we;
      logic valid_set;
   } store_ctl_type;

   function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
      sat_inc = (v == {TOTAL_W{1'b1}}) ? v : v + 1'b1;
   endfunction

endpackage

### src/apr_scan_unit.sv
// ----------------------------------------------------------------------------
// apr_scan_unit
// Per-frame compare and shift unit, reused once per frame during a scan.
// ----------------------------------------------------------------------------
module apr_scan_unit
   import apr_pkg::*;
#(
   parameter int PAGE_BITS = PAGE_BITS_DEF
) (
   input  logic                 entry_valid,
   input  logic [PAGE_BITS-1:0] entry_tag,
   input  logic [AGE_W-1:0]     entry_age,
   input  logic [PAGE_BITS-1:0] page,
   input  logic [AGE_W-1:0]     min_age,
   input  logic                 first,
   output logic                 match,
   output logic [AGE_W-1:0]     aged,
   output logic                 take_min
);

   logic [AGE_W-1:0] age_eff;

   // an empty frame reads as age zero
   assign age_eff  = entry_valid ? entry_age : '0;
   assign aged     = age_eff >> 1;
   assign match    = entry_valid && (entry_tag == page);
   assign take_min = first || (aged < min_age);

endmodule

### src/apr_frame_store.sv
// ----------------------------------------------------------------------------
// apr_frame_store
// Frame tag and age memories with per-frame valid bits, one read and one
// write per cycle.
// ----------------------------------------------------------------------------
module apr_frame_store
   import apr_pkg::*;
#(
   parameter int FRAMES    = FRAMES_DEF,
   parameter int PAGE_BITS = PAGE_BITS_DEF,
   parameter int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [IDX_W-1:0]     rd_addr,
   output logic                 rd_valid,
   output logic [PAGE_BITS-1:0] rd_tag,
   output logic [AGE_W-1:0]     rd_age,
   input  store_ctl_type        wr_ctl,
   input  logic [IDX_W-1:0]     wr_addr,
   input  logic [PAGE_BITS-1:0] wr_tag,
   input  logic [AGE_W-1:0]     wr_age
);

   logic [PAGE_BITS-1:0] tag_mem [FRAMES];
   logic [AGE_W-1:0]     age_mem [FRAMES];
   logic [FRAMES-1:0]    valid_ff;
   logic [FRAMES-1:0]    valid_in;

   always_comb begin
      valid_in = valid_ff;
      if (wr_ctl.valid_set) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_valid <= valid_ff[rd_addr];
      rd_tag   <= tag_mem[rd_addr];
      rd_age   <= age_mem[rd_addr];
      if (wr_ctl.tag_we) begin
         tag_mem[wr_addr] <= wr_tag;
      end
      if (wr_ctl.age_we) begin
         age_mem[wr_addr] <= wr_age;
      end
   end

endmodule

### src/aging_page_replacement.sv
// ----------------------------------------------------------------------------
// aging_page_replacement
// Aging page replacement with 8-bit counters: one page reference per request,
// hit/miss, frame used and saturating hit and miss totals per response.
// ----------------------------------------------------------------------------
//  channel   direction  tdata                                   tuser
//  req_      in         [19:0] page_number                      -
//  rsp_      out        [5:0] frame_index, [37:6] hit_total,    [0] hit
//                       [69:38] miss_total
//
//  a request passes through the accept in idle, a scan at one frame per cycle
//  through the shared compare/shift unit on the store's single read port, a
//  pipeline drain state and a write-back state.
//  reset is synchronous; valid bits clear at once, no clearing pass.
//  a new request is taken while the previous response still waits; the
//  write-back holds until the response register is free.
// ----------------------------------------------------------------------------
module aging_page_replacement
   import apr_pkg::*;
#(
   parameter int FRAMES    = FRAMES_DEF,
   parameter int PAGE_BITS = PAGE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [19:0] page_number
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // frame_index, hit_total, miss_total
   output logic                   rsp_tuser    // hit
);

   localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAMES - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE
   } state_type;

   state_type            state_ff, state_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic [IDX_W-1:0]     rd_addr_ff, rd_addr_in;
   logic                 p_vld_ff, p_vld_in;
   logic [IDX_W-1:0]     p_addr_ff, p_addr_in;
   logic                 first_ff, first_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     hit_idx_ff, hit_idx_in;
   logic [AGE_W-1:0]     hit_age_ff, hit_age_in;
   logic [AGE_W-1:0]     min_age_ff, min_age_in;
   logic [IDX_W-1:0]     min_idx_ff, min_idx_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   logic [IDX_FIELD_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [TOTAL_W-1:0]     hit_total_ff, hit_total_in;
   logic [TOTAL_W-1:0]     miss_total_ff, miss_total_in;

   logic                 rd_valid;
   logic [PAGE_BITS-1:0] rd_tag;
   logic [AGE_W-1:0]     rd_age;
   store_ctl_type        wr_ctl;
   logic [IDX_W-1:0]     wr_addr;
   logic [AGE_W-1:0]     wr_age;

   logic                 match;
   logic [AGE_W-1:0]     aged;
   logic                 take_min;
   logic                 req_take;
   logic                 upd_go;
   logic [IDX_W-1:0]     used_idx;

   apr_frame_store #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS),
      .IDX_W     (IDX_W)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (rd_addr_ff),
      .rd_valid (rd_valid),
      .rd_tag   (rd_tag),
      .rd_age   (rd_age),
      .wr_ctl   (wr_ctl),
      .wr_addr  (wr_addr),
      .wr_tag   (page_ff),
      .wr_age   (wr_age)
   );

   apr_scan_unit #(
      .PAGE_BITS (PAGE_BITS)
   ) u_scan (
      .entry_valid (rd_valid),
      .entry_tag   (rd_tag),
      .entry_age   (rd_age),
      .page        (page_ff),
      .min_age     (min_age_ff),
      .first       (first_ff),
      .match       (match),
      .aged        (aged),
      .take_min    (take_min)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign upd_go     = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_tready);
   assign used_idx   = found_ff ? hit_idx_ff : min_idx_ff;

   // store write port: aged counter during the scan, chosen frame at write-back
   always_comb begin
      wr_ctl    = '0;
      wr_addr   = p_addr_ff;
      wr_age    = aged;
      if (p_vld_ff) begin
         wr_ctl.age_we = 1'b1;
      end else if (upd_go) begin
         wr_addr          = used_idx;
         wr_ctl.age_we    = 1'b1;
         wr_ctl.tag_we    = !found_ff;
         wr_ctl.valid_set = !found_ff;
         wr_age           = found_ff ? (hit_age_ff | AGE_TOP) : AGE_TOP;
      end
   end

   always_comb begin
      state_in      = state_ff;
      page_in       = page_ff;
      rd_addr_in    = rd_addr_ff;
      p_vld_in      = 1'b0;
      p_addr_in     = rd_addr_ff;
      first_in      = first_ff;
      found_in      = found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_age_in    = hit_age_ff;
      min_age_in    = min_age_ff;
      min_idx_in    = min_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_hit_in    = rsp_hit_ff;
      rsp_idx_in    = rsp_idx_ff;
      hit_total_in  = hit_total_ff;
      miss_total_in = miss_total_ff;

      if (p_vld_ff) begin
         first_in = 1'b0;
         if (match && !found_ff) begin
            found_in   = 1'b1;
            hit_idx_in = p_addr_ff;
            hit_age_in = aged;
         end
         if (take_min) begin
            min_age_in = aged;
            min_idx_in = p_addr_ff;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               page_in    = PAGE_BITS'(req_tdata[PAGE_FIELD_W-1:0]);
               rd_addr_in = '0;
               first_in   = 1'b1;
               found_in   = 1'b0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            p_vld_in = 1'b1;
            if (rd_addr_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end else begin
               rd_addr_in = rd_addr_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (upd_go) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = found_ff;
               rsp_idx_in   = IDX_FIELD_W'(used_idx);
               if (found_ff) begin
                  hit_total_in = sat_inc(hit_total_ff);
               end else begin
                  miss_total_in = sat_inc(miss_total_ff);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         p_vld_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         hit_total_ff  <= '0;
         miss_total_ff <= '0;
      end else begin
         state_ff      <= state_in;
         p_vld_ff      <= p_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         hit_total_ff  <= hit_total_in;
         miss_total_ff <= miss_total_in;
      end
      page_ff    <= page_in;
      rd_addr_ff <= rd_addr_in;
      p_addr_ff  <= p_addr_in;
      first_ff   <= first_in;
      found_ff   <= found_in;
      hit_idx_ff <= hit_idx_in;
      hit_age_ff <= hit_age_in;
      min_age_ff <= min_age_in;
      min_idx_ff <= min_idx_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_idx_ff <= rsp_idx_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = {2'b00, miss_total_ff, hit_total_ff, rsp_idx_ff};

   a_take_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_SCAN))
      else $error("accepted request did not start a scan");

   a_idle_no_pipe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !p_vld_ff)
      else $error("scan pipeline busy while idle");

   a_update_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) && !upd_go |=> (state_ff == ST_UPDATE))
      else $error("write-back left before the response register was free");

   a_hit_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_hit_ff |-> (hit_total_ff != '0))
      else $error("hit response with zero hit total");

   a_miss_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_hit_ff |-> (miss_total_ff != '0))
      else $error("miss response with zero miss total");

endmodule
